FILE: hw/rtl/servo_angle_mode_manager_macros.svh
// assertion macros shared by the checker
`ifndef SERVO_ANGLE_MODE_MANAGER_MACROS_SVH
`define SERVO_ANGLE_MODE_MANAGER_MACROS_SVH

// property checked only outside reset
`define SAMM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("samm assertion failed");

// property checked on every edge, reset included
`define SAMM_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("samm assertion failed");

`endif

FILE: hw/rtl/samm_pkg.sv
package samm_pkg;

  // input word
  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  key_num;
    logic [15:0] light_level;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] servo_angle;
    logic [1:0] mode;
    logic [7:0] manual_setting;
    logic [2:0] edit_index;
    logic [4:0] on_hour;
    logic [5:0] on_minute;
    logic [4:0] off_hour;
    logic [5:0] off_minute;
    logic [7:0] timer_angle;
    logic       in_window;
  } out_word_t;

  // event kinds
  localparam logic [1:0] FUNC_SWITCH = 2'd0;
  localparam logic [1:0] FUNC_KEY    = 2'd1;
  localparam logic [1:0] FUNC_LIGHT  = 2'd2;
  localparam logic [1:0] FUNC_CLOCK  = 2'd3;

  // modes
  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_TIMER  = 2'd2;

  // keys that act
  localparam logic [2:0] KEY_NEXT = 3'd2;
  localparam logic [2:0] KEY_UP   = 3'd3;
  localparam logic [2:0] KEY_DOWN = 3'd4;

  // timer settings selected by the edit index
  localparam logic [2:0] EDIT_ON_HOUR  = 3'd0;
  localparam logic [2:0] EDIT_ON_MIN   = 3'd1;
  localparam logic [2:0] EDIT_OFF_HOUR = 3'd2;
  localparam logic [2:0] EDIT_OFF_MIN  = 3'd3;
  localparam logic [2:0] EDIT_ANGLE    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_BAND_ONE   = 2'd0;
  localparam logic [1:0] REG_BAND_TWO   = 2'd1;
  localparam logic [1:0] REG_BAND_THREE = 2'd2;
  localparam logic [1:0] REG_BAND_FOUR  = 2'd3;

  // band reset values
  localparam logic [15:0] BAND_ONE_RST   = 16'd50;
  localparam logic [15:0] BAND_TWO_RST   = 16'd100;
  localparam logic [15:0] BAND_THREE_RST = 16'd200;
  localparam logic [15:0] BAND_FOUR_RST  = 16'd500;

  // angles
  localparam logic [7:0] ANGLE_0   = 8'd0;
  localparam logic [7:0] ANGLE_30  = 8'd30;
  localparam logic [7:0] ANGLE_90  = 8'd90;
  localparam logic [7:0] ANGLE_150 = 8'd150;
  localparam logic [7:0] ANGLE_180 = 8'd180;
  localparam logic [7:0] DEG_STEP  = 8'd30;

  // clock limits
  localparam logic [4:0] HOUR_LAST = 5'd23;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [2:0] EDIT_LAST = 3'd4;

  // state reset values
  localparam logic [4:0] ON_HOUR_RST  = 5'd8;
  localparam logic [5:0] ON_MIN_RST   = 6'd0;
  localparam logic [4:0] OFF_HOUR_RST = 5'd19;
  localparam logic [5:0] OFF_MIN_RST  = 6'd0;

endpackage

FILE: hw/rtl/samm_in_stage.sv
module samm_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  samm_pkg::in_word_t  in_data,
  output logic                s_valid,
  input  logic                s_ready,
  output samm_pkg::in_word_t  s_data
);

  logic               v_r;
  samm_pkg::in_word_t data_r;

  // room when empty or when the held word leaves this cycle
  assign in_ready = !v_r || s_ready;
  assign s_valid  = v_r;
  assign s_data   = data_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

FILE: hw/rtl/samm_core.sv
module samm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                fire,
  input  samm_pkg::in_word_t  item,
  output samm_pkg::out_word_t res
);

  // light bands
  logic [15:0] band1_r, band2_r, band3_r, band4_r;

  // controller state
  logic [1:0] mode_r, mode_nxt;
  logic [7:0] manual_r, manual_nxt;
  logic [7:0] angle_r, angle_nxt;
  logic [2:0] index_r, index_nxt;
  logic [4:0] sh_r, sh_nxt;
  logic [5:0] sm_r, sm_nxt;
  logic [4:0] eh_r, eh_nxt;
  logic [5:0] em_r, em_nxt;
  logic [7:0] tangle_r, tangle_nxt;

  logic        hit;
  logic        up;
  logic [7:0]  light_angle;
  logic [8:0]  tangle_sum;
  logic [10:0] now_min, st_min, en_min;

  // hour * 60 + minute as shifts
  function automatic logic [10:0] to_minutes(input logic [4:0] h, input logic [5:0] m);
    logic [10:0] h64, h4;
    h64 = {h, 6'd0};
    h4  = {4'd0, h, 2'd0};
    return h64 - h4 + {5'd0, m};
  endfunction

  // band lookup, first band the light is below wins
  always_comb begin
    if (item.light_level < band1_r) begin
      light_angle = samm_pkg::ANGLE_0;
    end else if (item.light_level < band2_r) begin
      light_angle = samm_pkg::ANGLE_30;
    end else if (item.light_level < band3_r) begin
      light_angle = samm_pkg::ANGLE_90;
    end else if (item.light_level < band4_r) begin
      light_angle = samm_pkg::ANGLE_150;
    end else begin
      light_angle = samm_pkg::ANGLE_180;
    end
  end

  // time window bounds
  assign now_min    = to_minutes(item.hour, item.minute);
  assign st_min     = to_minutes(sh_r, sm_r);
  assign en_min     = to_minutes(eh_r, em_r);
  assign tangle_sum = {1'b0, tangle_r} + {1'b0, samm_pkg::DEG_STEP};
  assign up         = (item.key_num == samm_pkg::KEY_UP);

  // next state for one event
  always_comb begin
    mode_nxt   = mode_r;
    manual_nxt = manual_r;
    angle_nxt  = angle_r;
    index_nxt  = index_r;
    sh_nxt     = sh_r;
    sm_nxt     = sm_r;
    eh_nxt     = eh_r;
    em_nxt     = em_r;
    tangle_nxt = tangle_r;
    hit        = 1'b0;
    case (item.func)
      samm_pkg::FUNC_SWITCH: begin
        if (mode_r == samm_pkg::MODE_AUTO) begin
          mode_nxt   = samm_pkg::MODE_MANUAL;
          manual_nxt = samm_pkg::ANGLE_90;
        end else if (mode_r == samm_pkg::MODE_MANUAL) begin
          mode_nxt = samm_pkg::MODE_TIMER;
        end else begin
          mode_nxt = samm_pkg::MODE_AUTO;
        end
        index_nxt = samm_pkg::EDIT_ON_HOUR;
      end
      samm_pkg::FUNC_KEY: begin
        if (mode_r == samm_pkg::MODE_MANUAL) begin
          if (item.key_num == samm_pkg::KEY_NEXT) begin
            manual_nxt = (manual_r >= samm_pkg::ANGLE_180) ? samm_pkg::ANGLE_0
                                                           : manual_r + samm_pkg::DEG_STEP;
          end else if (item.key_num == samm_pkg::KEY_UP) begin
            manual_nxt = (manual_r == samm_pkg::ANGLE_0) ? samm_pkg::ANGLE_180
                                                         : manual_r - samm_pkg::DEG_STEP;
          end
        end else if (mode_r == samm_pkg::MODE_TIMER) begin
          if (item.key_num == samm_pkg::KEY_NEXT) begin
            index_nxt = (index_r >= samm_pkg::EDIT_LAST) ? samm_pkg::EDIT_ON_HOUR
                                                         : index_r + 3'd1;
          end else if (item.key_num == samm_pkg::KEY_UP ||
                       item.key_num == samm_pkg::KEY_DOWN) begin
            case (index_r)
              samm_pkg::EDIT_ON_HOUR: begin
                if (up) sh_nxt = (sh_r >= samm_pkg::HOUR_LAST) ? 5'd0 : sh_r + 5'd1;
                else    sh_nxt = (sh_r == 5'd0) ? samm_pkg::HOUR_LAST : sh_r - 5'd1;
              end
              samm_pkg::EDIT_ON_MIN: begin
                if (up) sm_nxt = (sm_r >= samm_pkg::MIN_LAST) ? 6'd0 : sm_r + 6'd1;
                else    sm_nxt = (sm_r == 6'd0) ? samm_pkg::MIN_LAST : sm_r - 6'd1;
              end
              samm_pkg::EDIT_OFF_HOUR: begin
                if (up) eh_nxt = (eh_r >= samm_pkg::HOUR_LAST) ? 5'd0 : eh_r + 5'd1;
                else    eh_nxt = (eh_r == 5'd0) ? samm_pkg::HOUR_LAST : eh_r - 5'd1;
              end
              samm_pkg::EDIT_OFF_MIN: begin
                if (up) em_nxt = (em_r >= samm_pkg::MIN_LAST) ? 6'd0 : em_r + 6'd1;
                else    em_nxt = (em_r == 6'd0) ? samm_pkg::MIN_LAST : em_r - 6'd1;
              end
              samm_pkg::EDIT_ANGLE: begin
                if (up) begin
                  tangle_nxt = (tangle_sum > {1'b0, samm_pkg::ANGLE_180}) ? samm_pkg::ANGLE_0
                                                                          : tangle_sum[7:0];
                end else begin
                  tangle_nxt = (tangle_r == samm_pkg::ANGLE_0) ? samm_pkg::ANGLE_180
                                                               : tangle_r - samm_pkg::DEG_STEP;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      samm_pkg::FUNC_LIGHT: begin
        if (mode_r == samm_pkg::MODE_AUTO) begin
          angle_nxt = light_angle;
        end else if (mode_r == samm_pkg::MODE_MANUAL) begin
          angle_nxt = manual_r;
        end
      end
      samm_pkg::FUNC_CLOCK: begin
        if (mode_r == samm_pkg::MODE_TIMER) begin
          // window may wrap past midnight
          if (st_min <= en_min) begin
            hit = (now_min >= st_min) && (now_min <= en_min);
          end else begin
            hit = (now_min >= st_min) || (now_min <= en_min);
          end
          angle_nxt = hit ? tangle_r : samm_pkg::ANGLE_0;
        end
      end
      default: begin
      end
    endcase
  end

  // result shows the state after the event
  always_comb begin
    res.servo_angle    = angle_nxt;
    res.mode           = mode_nxt;
    res.manual_setting = manual_nxt;
    res.edit_index     = index_nxt;
    res.on_hour        = sh_nxt;
    res.on_minute      = sm_nxt;
    res.off_hour       = eh_nxt;
    res.off_minute     = em_nxt;
    res.timer_angle    = tangle_nxt;
    res.in_window      = hit;
  end

  // controller state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= samm_pkg::MODE_AUTO;
      manual_r <= samm_pkg::ANGLE_90;
      angle_r  <= samm_pkg::ANGLE_0;
      index_r  <= samm_pkg::EDIT_ON_HOUR;
      sh_r     <= samm_pkg::ON_HOUR_RST;
      sm_r     <= samm_pkg::ON_MIN_RST;
      eh_r     <= samm_pkg::OFF_HOUR_RST;
      em_r     <= samm_pkg::OFF_MIN_RST;
      tangle_r <= samm_pkg::ANGLE_150;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      manual_r <= manual_nxt;
      angle_r  <= angle_nxt;
      index_r  <= index_nxt;
      sh_r     <= sh_nxt;
      sm_r     <= sm_nxt;
      eh_r     <= eh_nxt;
      em_r     <= em_nxt;
      tangle_r <= tangle_nxt;
    end
  end

  // band registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band1_r <= samm_pkg::BAND_ONE_RST;
      band2_r <= samm_pkg::BAND_TWO_RST;
      band3_r <= samm_pkg::BAND_THREE_RST;
      band4_r <= samm_pkg::BAND_FOUR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        samm_pkg::REG_BAND_ONE:   band1_r <= cfg_data;
        samm_pkg::REG_BAND_TWO:   band2_r <= cfg_data;
        samm_pkg::REG_BAND_THREE: band3_r <= cfg_data;
        samm_pkg::REG_BAND_FOUR:  band4_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/samm_out_stage.sv
module samm_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                r_valid,
  output logic                r_ready,
  input  samm_pkg::out_word_t r_data,
  output logic                out_valid,
  input  logic                out_ready,
  output samm_pkg::out_word_t out_data
);

  logic                v_r;
  samm_pkg::out_word_t data_r;

  // take a new result when empty or when the held one is taken
  assign r_ready   = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = data_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (r_ready) begin
      v_r <= r_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (r_valid && r_ready) begin
      data_r <= r_data;
    end
  end

endmodule

FILE: hw/rtl/servo_angle_mode_manager.sv
// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_ready  | in_data (in_word_t)
// out_     | output    | out_valid / out_ready| out_data (out_word_t)
// cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one word per cycle sustained while out_ready stays high; a word taken from in_data passes
// the input register, then the next-state logic, then the result register before out_data
// rst_n is synchronous; it restores modes, timer settings and light bands
// a stalled result holds in the output register while one more word waits in the input
// register; cfg_ready is always high
module servo_angle_mode_manager (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  samm_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output samm_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  logic                s_valid;
  logic                s_ready;
  samm_pkg::in_word_t  s_data;
  samm_pkg::out_word_t res;
  logic                fire;

  // config writes land at once
  assign cfg_ready = 1'b1;

  // event is applied when it moves into the result register
  assign fire = s_valid && s_ready;

  // input register
  samm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_data   (s_data)
  );

  // state and next-state logic
  samm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (s_data),
    .res       (res)
  );

  // result register
  samm_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .r_valid   (s_valid),
    .r_ready   (s_ready),
    .r_data    (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/samm_checker.sv
`include "servo_angle_mode_manager_macros.svh"

module samm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input samm_pkg::out_word_t out_data
);

  logic win_match;
  logic range_ok;

  // a window hit reports timer mode with the timer angle on the servo
  assign win_match = (out_data.mode == samm_pkg::MODE_TIMER) &&
                     (out_data.servo_angle == out_data.timer_angle);

  // mode and edit index stay in range
  assign range_ok = (out_data.mode <= samm_pkg::MODE_TIMER) &&
                    (out_data.edit_index <= samm_pkg::EDIT_LAST);

  // reset empties the result register
  `SAMM_ASSERT_ALL(a_reset_empty, clk, !rst_n |=> !out_valid)

  // a stalled word holds
  `SAMM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // window hit only in timer mode, and then the timer angle drives the servo
  `SAMM_ASSERT(a_window_timer, clk, rst_n, out_valid && out_data.in_window |-> win_match)

  // reported fields stay in range
  `SAMM_ASSERT(a_ranges, clk, rst_n, out_valid |-> range_ok)

  // an empty result register never refuses input
  `SAMM_ASSERT(a_in_room, clk, rst_n, !out_valid |-> in_ready)

endmodule

bind servo_angle_mode_manager samm_checker u_samm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
